// ===== hw/rtl/tfef_pkg.sv =====
// Package for the triangle element force core: widths and fixed-point helpers.
// No dependencies.
package tfef_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int W = 32;
   localparam int WO = 48;
   localparam int WP = 66;

   typedef logic signed [W-1:0] word_type;

   function automatic logic signed [W-1:0] sat32(input logic signed [WP-1:0] x);
      logic signed [WP-1:0] hi;
      logic signed [WP-1:0] lo;
      hi = WP'(signed'(32'sh7fffffff));
      lo = WP'(signed'(32'sh80000000));
      if (x > hi) sat32 = 32'sh7fffffff;
      else if (x < lo) sat32 = 32'sh80000000;
      else sat32 = x[W-1:0];
   endfunction

   function automatic logic signed [WO-1:0] sat48(input logic signed [WP-1:0] x);
      logic signed [WP-1:0] hi;
      logic signed [WP-1:0] lo;
      hi = (WP'(1) <<< (WO-1)) - WP'(1);
      lo = -(WP'(1) <<< (WO-1));
      if (x > hi) sat48 = hi[WO-1:0];
      else if (x < lo) sat48 = lo[WO-1:0];
      else sat48 = x[WO-1:0];
   endfunction

   // Rounds (x / 2^s) half toward plus infinity.
   function automatic logic signed [WP-1:0] rnd(input logic signed [WP-1:0] x,
                                                input int s);
      rnd = (x + (WP'(1) <<< (s-1))) >>> s;
   endfunction
endpackage

// ===== hw/rtl/tfef_pipe_ctl.sv =====
// Stall-aware valid tracking for one pipeline stage.
// Uses no package items.
module tfef_pipe_ctl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic advance,
   output logic out_valid
);
   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= in_valid;
   end
   assign out_valid = valid_ff;
endmodule

// ===== hw/rtl/triangle_fem_element_force_core.sv =====
// Triangle element force core, St. Venant-Kirchhoff linear triangle.
// Six register stages; a result is valid once its accepted request has passed all six.
// Throughput is one per cycle while the result is not stalled, and a stalled result holds every stage.
// Stages: edges, F, strain, stress, P, forces. At most one multiplier level per stage; edges has none.
// Reset clears only stage valid bits; payload registers are not reset.
// Depends on tfef_pkg and tfef_pipe_ctl.
module triangle_fem_element_force_core import tfef_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_pos0_x, req_pos0_y, req_pos1_x, req_pos1_y,
   input  logic signed [31:0] req_pos2_x, req_pos2_y,
   input  logic signed [31:0] req_inv_ref_r0c0, req_inv_ref_r0c1,
   input  logic signed [31:0] req_inv_ref_r1c0, req_inv_ref_r1c1,
   input  logic [30:0] req_scaled_lambda, req_scaled_mu,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [47:0] rsp_force0_x, rsp_force0_y, rsp_force1_x,
   output logic signed [47:0] rsp_force1_y, rsp_force2_x, rsp_force2_y
);
   logic adv;
   logic [5:0] v;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = v[5];

   tfef_pipe_ctl u_c0 (.clock, .reset, .in_valid(req_valid), .advance(adv), .out_valid(v[0]));
   for (genvar i = 1; i < 6; i++) begin : g_ctl
      tfef_pipe_ctl u_c (.clock, .reset, .in_valid(v[i-1]), .advance(adv), .out_valid(v[i]));
   end

   function automatic logic signed [WP-1:0] x(input logic signed [W-1:0] a);
      x = WP'(a);
   endfunction

   // Stage 1: edges.
   word_type d1x_ff, d1y_ff, d2x_ff, d2y_ff, a1_ff, b1_ff, c1_ff, e1_ff;
   logic [30:0] lam1_ff, mu1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         d1x_ff <= sat32(x(req_pos1_x) - x(req_pos0_x));
         d1y_ff <= sat32(x(req_pos1_y) - x(req_pos0_y));
         d2x_ff <= sat32(x(req_pos2_x) - x(req_pos0_x));
         d2y_ff <= sat32(x(req_pos2_y) - x(req_pos0_y));
         a1_ff <= req_inv_ref_r0c0; b1_ff <= req_inv_ref_r0c1;
         c1_ff <= req_inv_ref_r1c0; e1_ff <= req_inv_ref_r1c1;
         lam1_ff <= req_scaled_lambda; mu1_ff <= req_scaled_mu;
      end
   end

   // Stage 2: F.
   word_type f00_ff, f01_ff, f10_ff, f11_ff, a2_ff, b2_ff, c2_ff, e2_ff;
   logic [30:0] lam2_ff, mu2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         f00_ff <= sat32(rnd(x(d1x_ff) * x(a1_ff) + x(d2x_ff) * x(c1_ff), FRAC_BITS));
         f01_ff <= sat32(rnd(x(d1x_ff) * x(b1_ff) + x(d2x_ff) * x(e1_ff), FRAC_BITS));
         f10_ff <= sat32(rnd(x(d1y_ff) * x(a1_ff) + x(d2y_ff) * x(c1_ff), FRAC_BITS));
         f11_ff <= sat32(rnd(x(d1y_ff) * x(b1_ff) + x(d2y_ff) * x(e1_ff), FRAC_BITS));
         a2_ff <= a1_ff; b2_ff <= b1_ff; c2_ff <= c1_ff; e2_ff <= e1_ff;
         lam2_ff <= lam1_ff; mu2_ff <= mu1_ff;
      end
   end

   // Stage 3: strain and trace; node 0 gradient.
   logic signed [WP-1:0] one_sq, e00_in, e11_in;
   assign one_sq = WP'(1) <<< (2*FRAC_BITS);
   assign e00_in = WP'(sat32(rnd(x(f00_ff) * x(f00_ff) + x(f10_ff) * x(f10_ff) - one_sq,
                                 FRAC_BITS+1)));
   assign e11_in = WP'(sat32(rnd(x(f01_ff) * x(f01_ff) + x(f11_ff) * x(f11_ff) - one_sq,
                                 FRAC_BITS+1)));
   word_type f00_3_ff, f01_3_ff, f10_3_ff, f11_3_ff, e00_ff, e11_ff, e01_ff, tr_ff;
   word_type a3_ff, b3_ff, c3_ff, e3_ff, g0x3_ff, g0y3_ff;
   logic [30:0] lam3_ff, mu3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         e00_ff <= e00_in[W-1:0];
         e11_ff <= e11_in[W-1:0];
         tr_ff <= sat32(e00_in + e11_in);
         e01_ff <= sat32(rnd(x(f00_ff) * x(f01_ff) + x(f10_ff) * x(f11_ff), FRAC_BITS+1));
         f00_3_ff <= f00_ff; f01_3_ff <= f01_ff; f10_3_ff <= f10_ff; f11_3_ff <= f11_ff;
         a3_ff <= a2_ff; b3_ff <= b2_ff; c3_ff <= c2_ff; e3_ff <= e2_ff;
         g0x3_ff <= sat32(-(x(a2_ff) + x(c2_ff)));
         g0y3_ff <= sat32(-(x(b2_ff) + x(e2_ff)));
         lam3_ff <= lam2_ff; mu3_ff <= mu2_ff;
      end
   end

   // Stage 4: stress.
   logic signed [WP-1:0] lam_x, mu_x;
   assign lam_x = WP'(signed'({1'b0, lam3_ff}));
   assign mu_x = WP'(signed'({1'b0, mu3_ff}));
   word_type s00_ff, s11_ff, s01_ff, f00_4_ff, f01_4_ff, f10_4_ff, f11_4_ff;
   word_type a4_ff, b4_ff, c4_ff, e4_ff, g0x4_ff, g0y4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s00_ff <= sat32(rnd(lam_x * x(tr_ff) + ((mu_x * x(e00_ff)) <<< 1), FRAC_BITS));
         s11_ff <= sat32(rnd(lam_x * x(tr_ff) + ((mu_x * x(e11_ff)) <<< 1), FRAC_BITS));
         s01_ff <= sat32(rnd((mu_x * x(e01_ff)) <<< 1, FRAC_BITS));
         f00_4_ff <= f00_3_ff; f01_4_ff <= f01_3_ff;
         f10_4_ff <= f10_3_ff; f11_4_ff <= f11_3_ff;
         a4_ff <= a3_ff; b4_ff <= b3_ff; c4_ff <= c3_ff; e4_ff <= e3_ff;
         g0x4_ff <= g0x3_ff; g0y4_ff <= g0y3_ff;
      end
   end

   // Stage 5: first Piola-Kirchhoff stress.
   word_type p00_ff, p01_ff, p10_ff, p11_ff, a5_ff, b5_ff, c5_ff, e5_ff, g0x5_ff, g0y5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p00_ff <= sat32(rnd(x(f00_4_ff) * x(s00_ff) + x(f01_4_ff) * x(s01_ff), FRAC_BITS));
         p01_ff <= sat32(rnd(x(f00_4_ff) * x(s01_ff) + x(f01_4_ff) * x(s11_ff), FRAC_BITS));
         p10_ff <= sat32(rnd(x(f10_4_ff) * x(s00_ff) + x(f11_4_ff) * x(s01_ff), FRAC_BITS));
         p11_ff <= sat32(rnd(x(f10_4_ff) * x(s01_ff) + x(f11_4_ff) * x(s11_ff), FRAC_BITS));
         a5_ff <= a4_ff; b5_ff <= b4_ff; c5_ff <= c4_ff; e5_ff <= e4_ff;
         g0x5_ff <= g0x4_ff; g0y5_ff <= g0y4_ff;
      end
   end

   // Stage 6: nodal forces.
   function automatic logic signed [WO-1:0] nf(input word_type p0, p1, gx, gy);
      nf = sat48(-rnd(x(p0) * x(gx) + x(p1) * x(gy), FRAC_BITS));
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_force0_x <= nf(p00_ff, p01_ff, g0x5_ff, g0y5_ff);
         rsp_force0_y <= nf(p10_ff, p11_ff, g0x5_ff, g0y5_ff);
         rsp_force1_x <= nf(p00_ff, p01_ff, a5_ff, b5_ff);
         rsp_force1_y <= nf(p10_ff, p11_ff, a5_ff, b5_ff);
         rsp_force2_x <= nf(p00_ff, p01_ff, c5_ff, e5_ff);
         rsp_force2_y <= nf(p10_ff, p11_ff, c5_ff, e5_ff);
      end
   end
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for triangle_fem_element_force_core: drives directed triangles,
// then random bursts, and stalls results, predicting each nodal force set itself.
// Depends on tfef_pkg and the core RTL.
module tb;
   import tfef_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1700;

   typedef logic signed [95:0] wide_type;

   typedef struct {
      logic signed [31:0] x0, y0, x1, y1, x2, y2;
      logic signed [31:0] a, b, c, d;
      logic [30:0] lam, mu;
   } triangle_type;

   typedef struct {
      logic signed [47:0] f [6];
   } forces_type;

   class force_scoreboard;
      forces_type pending [$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function wide_type sat(wide_type x, int bits);
         wide_type lim;
         lim = wide_type'(1) <<< (bits - 1);
         if (x > lim - 1) return lim - 1;
         if (x < -lim) return -lim;
         return x;
      endfunction

      function wide_type rnd(wide_type x, int s);
         return (x + (wide_type'(1) <<< (s - 1))) >>> s;
      endfunction

      function wide_type mac(wide_type p, wide_type q, wide_type r, wide_type t);
         return sat(rnd(p * q + r * t, FRAC), 32);
      endfunction

      function void note_triangle(triangle_type t);
         wide_type a, b, c, d, lam, mu, one, d1x, d1y, d2x, d2y;
         wide_type f00, f01, f10, f11, e00, e11, e01, tr, s00, s11, s01;
         wide_type p00, p01, p10, p11, gx [3], gy [3];
         forces_type exp_f;
         a = wide_type'(t.a); b = wide_type'(t.b);
         c = wide_type'(t.c); d = wide_type'(t.d);
         lam = wide_type'(t.lam);
         mu = wide_type'(t.mu);
         one = wide_type'(1) <<< FRAC;
         d1x = sat(wide_type'(t.x1) - wide_type'(t.x0), 32);
         d1y = sat(wide_type'(t.y1) - wide_type'(t.y0), 32);
         d2x = sat(wide_type'(t.x2) - wide_type'(t.x0), 32);
         d2y = sat(wide_type'(t.y2) - wide_type'(t.y0), 32);
         f00 = mac(d1x, a, d2x, c);
         f01 = mac(d1x, b, d2x, d);
         f10 = mac(d1y, a, d2y, c);
         f11 = mac(d1y, b, d2y, d);
         e00 = sat(rnd(f00 * f00 + f10 * f10 - one * one, FRAC + 1), 32);
         e11 = sat(rnd(f01 * f01 + f11 * f11 - one * one, FRAC + 1), 32);
         e01 = sat(rnd(f00 * f01 + f10 * f11, FRAC + 1), 32);
         tr = sat(e00 + e11, 32);
         s00 = sat(rnd(lam * tr + 2 * (mu * e00), FRAC), 32);
         s11 = sat(rnd(lam * tr + 2 * (mu * e11), FRAC), 32);
         s01 = sat(rnd(2 * (mu * e01), FRAC), 32);
         p00 = mac(f00, s00, f01, s01);
         p01 = mac(f00, s01, f01, s11);
         p10 = mac(f10, s00, f11, s01);
         p11 = mac(f10, s01, f11, s11);
         gx[0] = sat(-(a + c), 32);
         gy[0] = sat(-(b + d), 32);
         gx[1] = a; gy[1] = b;
         gx[2] = c; gy[2] = d;
         for (int n = 0; n < 3; n++) begin
            exp_f.f[2*n] = 48'(sat(-rnd(p00 * gx[n] + p01 * gy[n], FRAC), 48));
            exp_f.f[2*n+1] = 48'(sat(-rnd(p10 * gx[n] + p11 * gy[n], FRAC), 48));
         end
         pending.push_back(exp_f);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_forces(forces_type got);
         forces_type exp_f;
         if (pending.size() == 0) begin
            report("result with no transaction outstanding");
            return;
         end
         exp_f = pending.pop_front();
         for (int k = 0; k < 6; k++)
            if (got.f[k] !== exp_f.f[k])
               report($sformatf("force field %0d got %0d expected %0d",
                                k, got.f[k], exp_f.f[k]));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   triangle_type drv = '{default: '0};
   logic signed [47:0] rsp_f [6];
   force_scoreboard sb = new();
   int cycles = 0;

   triangle_fem_element_force_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos0_x(drv.x0), .req_pos0_y(drv.y0), .req_pos1_x(drv.x1),
      .req_pos1_y(drv.y1), .req_pos2_x(drv.x2), .req_pos2_y(drv.y2),
      .req_inv_ref_r0c0(drv.a), .req_inv_ref_r0c1(drv.b),
      .req_inv_ref_r1c0(drv.c), .req_inv_ref_r1c1(drv.d),
      .req_scaled_lambda(drv.lam), .req_scaled_mu(drv.mu),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_force0_x(rsp_f[0]), .rsp_force0_y(rsp_f[1]), .rsp_force1_x(rsp_f[2]),
      .rsp_force1_y(rsp_f[3]), .rsp_force2_x(rsp_f[4]), .rsp_force2_y(rsp_f[5])
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      forces_type got;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && req_valid && !req_stall) sb.note_triangle(drv);
      if (!reset && rsp_valid && !rsp_stall) begin
         for (int k = 0; k < 6; k++) got.f[k] = rsp_f[k];
         sb.check_forces(got);
      end
   end

   int stall_mode = 0;
   always @(negedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= ((cycles / 3) % 2 == 1);
      endcase
   end

   function automatic logic signed [31:0] rand_word(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         2: return 32'sh0001_0000 + $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
         default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   function automatic triangle_type rand_triangle();
      triangle_type t;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         t.x0 = rand_word(0); t.y0 = rand_word(0); t.x1 = rand_word(0);
         t.y1 = rand_word(0); t.x2 = rand_word(0); t.y2 = rand_word(0);
         t.a = rand_word(0); t.b = rand_word(0); t.c = rand_word(0);
         t.d = rand_word(0);
         t.lam = 31'($urandom); t.mu = 31'($urandom);
      end else begin
         t.x0 = rand_word(1); t.y0 = rand_word(1);
         t.x1 = t.x0 + 32'sh0001_0000 + rand_word(1) / 8;
         t.y1 = t.y0 + rand_word(1) / 8;
         t.x2 = t.x0 + rand_word(1) / 8;
         t.y2 = t.y0 + 32'sh0001_0000 + rand_word(1) / 8;
         t.a = rand_word(2); t.b = rand_word(1) / 16;
         t.c = rand_word(1) / 16; t.d = rand_word(2);
         t.lam = 31'($urandom_range(0, 32'h0010_0000));
         t.mu = 31'($urandom_range(0, 32'h0010_0000));
         if (kind == 9) begin
            t.x1 = rand_word(3); t.lam = $urandom_range(0, 1) ? 31'h7fffffff : '0;
            t.c = rand_word(3);
         end
      end
      return t;
   endfunction

   task automatic send_triangle(triangle_type t);
      @(negedge clock);
      drv <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(int gap);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   triangle_type directed [$];

   initial begin
      triangle_type t;
      int left;
      int burst;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      t = '{default: '0};
      directed.push_back(t);
      t.x1 = 32'sh0001_0000; t.y2 = 32'sh0001_0000;
      t.a = 32'sh0001_0000; t.d = 32'sh0001_0000;
      t.lam = 31'h0001_0000; t.mu = 31'h0000_8000;
      directed.push_back(t);
      t.x1 = 32'sh0001_8000; t.y1 = 32'sh0000_4000;
      directed.push_back(t);
      t.x0 = 32'sh80000000; t.x1 = 32'sh7fffffff;
      t.y0 = 32'sh7fffffff; t.y2 = 32'sh80000000;
      directed.push_back(t);
      t = '{default: '0};
      t.x1 = 32'sh0002_0000; t.y2 = 32'sh0002_0000;
      t.a = 32'sh80000000; t.c = 32'sh80000000;
      t.b = 32'sh7fffffff; t.d = 32'sh7fffffff;
      t.lam = 31'h7fffffff; t.mu = 31'h7fffffff;
      directed.push_back(t);
      t = '{x0: 32'sh80000000, y0: 32'sh80000000, x1: 32'sh7fffffff,
            y1: 32'sh7fffffff, x2: 32'sh7fffffff, y2: 32'sh80000000,
            a: 32'sh7fffffff, b: 32'sh80000000, c: 32'sh7fffffff,
            d: 32'sh7fffffff, lam: 31'h7fffffff, mu: 31'h7fffffff};
      directed.push_back(t);
      t = '{default: '1};
      directed.push_back(t);
      t = '{default: '0};
      t.x1 = 32'sh0000_0001; t.y2 = 32'sh0000_0001;
      t.a = 32'sh0000_0001; t.d = 32'sh0000_0001; t.mu = 31'h1;
      directed.push_back(t);
      t = '{default: '0};
      t.x1 = 32'sh0000_8000; t.y2 = 32'sh0000_8000;
      t.a = 32'sh0001_0000; t.d = 32'sh0001_0000;
      t.lam = 31'h0000_0001; t.mu = 31'h7fffffff;
      directed.push_back(t);
      foreach (directed[i]) send_triangle(directed[i]);

      left = RANDOM_ITEMS;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) send_triangle(rand_triangle());
         left -= burst;
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 8));
      end
      pause_sender(0);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
